>>> hdl/bffl_pkg.sv
`default_nettype none
package bffl_pkg;

    localparam int DATA_W       = 32;
    localparam int ADJ_W        = 12;
    localparam int LOG2_W       = 4;
    localparam int STATUS_W     = 2;
    localparam int CFG_IDX_W    = 1;
    localparam int ADDR_BITS    = 32;
    localparam int HEADER_BYTES = 16;
    localparam logic [LOG2_W-1:0] MAX_ALIGN_LOG2 = 4'd12;
    localparam logic [ADJ_W-1:0]  ADJ_MAX        = 12'hFFF;

    // highest usable end address of the pool
    localparam logic [DATA_W-1:0] END_LIMIT = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF
        : 32'((64'd1 << ADDR_BITS) - 64'd1);

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FIT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = 1'd1;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] start;
        logic [DATA_W-1:0] len;
    } t_seg;

endpackage
`default_nettype wire

>>> hdl/best_fit_free_list_allocator_top.sv
// Channel   Direction  Handshake              Payload
// request   in         i_valid / o_stall      req_type, req_size, align_log2, free_*
// result    out        o_valid / i_stall      status, addr, block_size, adjust, counters
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
// Allocate: reads then evaluates each entry scanned; moves entries on a remove.
// Free: reads the entries below the block and the one above, then shifts entries.
// One table port pair (one write, one registered read) serves all of these steps.
// After reset and after each config write, the INIT state rebuilds the table.
// An offered config write holds off requests; it wins over a request in idle.
// A finished result waits in the output register while the next request is taken.
`default_nettype none
module best_fit_free_list_allocator_top #(
    parameter int MAX_SEGMENTS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic                                i_req_type,
    input  wire logic [bffl_pkg::DATA_W-1:0]         i_req_size,
    input  wire logic [bffl_pkg::LOG2_W-1:0]         i_align_log2,
    input  wire logic [bffl_pkg::DATA_W-1:0]         i_free_addr,
    input  wire logic [bffl_pkg::ADJ_W-1:0]          i_free_adjust,
    input  wire logic [bffl_pkg::DATA_W-1:0]         i_free_size,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [bffl_pkg::STATUS_W-1:0]            o_status,
    output logic [bffl_pkg::DATA_W-1:0]              o_addr,
    output logic [bffl_pkg::DATA_W-1:0]              o_block_size,
    output logic [bffl_pkg::ADJ_W-1:0]               o_adjust,
    output logic [bffl_pkg::DATA_W-1:0]              o_used_bytes,
    output logic [bffl_pkg::DATA_W-1:0]              o_alloc_count,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [bffl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [bffl_pkg::DATA_W-1:0]         i_cfg_data
);
    import bffl_pkg::*;

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);
    localparam logic [CW-1:0] ONE     = CW'(1);

    typedef enum logic [10:0] {
        S_INIT = 11'b000_0000_0001,
        S_IDLE = 11'b000_0000_0010,
        S_ARD  = 11'b000_0000_0100,
        S_AEV  = 11'b000_0000_1000,
        S_ADEC = 11'b000_0001_0000,
        S_FPRE = 11'b000_0010_0000,
        S_FRD  = 11'b000_0100_0000,
        S_FEV  = 11'b000_1000_0000,
        S_FCHK = 11'b001_0000_0000,
        S_MOVE = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_mv_wr, n_mv_wr;   // second half of a move step
    logic [DATA_W-1:0] r_pool_base, n_pool_base, r_pool_size, n_pool_size;
    logic [CW-1:0] r_cnt, n_cnt, r_idx, n_idx, r_mv, n_mv, r_mv_last, n_mv_last;
    logic          r_mv_rm, n_mv_rm;
    logic [DATA_W-1:0] r_used, n_used, r_live, n_live;
    logic [DATA_W-1:0] r_size, n_size;
    logic [LOG2_W-1:0] r_lg, n_lg;
    logic          r_has_best, n_has_best;
    logic [CW-1:0] r_best, n_best;
    t_seg          r_best_seg, n_best_seg;
    logic [ADJ_W-1:0]  r_badj, n_badj;
    logic [DATA_W-1:0] r_btot, n_btot;
    logic [DATA_W-1:0] r_bstart, n_bstart, r_fsize, n_fsize;
    logic [DATA_W:0]   r_bend, n_bend;
    logic          r_bad, n_bad;
    logic          r_has_prev, n_has_prev, r_has_next, n_has_next;
    t_seg          r_prev, n_prev, r_next, n_next;
    logic          r_fin_we, n_fin_we;
    logic [IW-1:0] r_fin_addr, n_fin_addr;
    t_seg          r_fin, n_fin;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [DATA_W-1:0]   r_addr, n_addr, r_bsize, n_bsize;
    logic [ADJ_W-1:0]    r_adj, n_adj;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [DATA_W-1:0]   r_out_addr, n_out_addr, r_out_bsize, n_out_bsize;
    logic [ADJ_W-1:0]    r_out_adj, n_out_adj;
    logic [DATA_W-1:0]   r_out_used, n_out_used, r_out_live, n_out_live;

    logic          mem_we;
    logic [IW-1:0] mem_waddr, mem_raddr;
    t_seg          mem_wdata, mem_rdata;

    logic [ADJ_W-1:0]  fit_adj;
    logic [DATA_W-1:0] fit_total;
    logic              fit_ok, fit_exact;

    logic [DATA_W-1:0] init_base, init_avail, rem;
    logic [DATA_W:0]   prev_end;
    logic              mprev, mnext, accept;

    bffl_seg_mem #(.DEPTH(MAX_SEGMENTS), .IW(IW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bffl_fit u_fit (
        .i_seg   (mem_rdata),
        .i_size  (r_size),
        .i_lg    (r_lg),
        .o_adj   (fit_adj),
        .o_total (fit_total),
        .o_fit   (fit_ok),
        .o_exact (fit_exact)
    );

    assign o_stall     = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign accept      = i_valid && !o_stall;

    always_comb begin
        n_state = r_state;  n_mv_wr = r_mv_wr;
        n_pool_base = r_pool_base;  n_pool_size = r_pool_size;
        n_cnt = r_cnt;  n_idx = r_idx;  n_mv = r_mv;  n_mv_last = r_mv_last;
        n_mv_rm = r_mv_rm;  n_used = r_used;  n_live = r_live;
        n_size = r_size;  n_lg = r_lg;  n_has_best = r_has_best;  n_best = r_best;
        n_best_seg = r_best_seg;  n_badj = r_badj;  n_btot = r_btot;
        n_bstart = r_bstart;  n_fsize = r_fsize;  n_bend = r_bend;  n_bad = r_bad;
        n_has_prev = r_has_prev;  n_has_next = r_has_next;
        n_prev = r_prev;  n_next = r_next;
        n_fin_we = r_fin_we;  n_fin_addr = r_fin_addr;  n_fin = r_fin;
        n_status = r_status;  n_addr = r_addr;  n_bsize = r_bsize;  n_adj = r_adj;
        n_out_valid = r_out_valid;  n_out_status = r_out_status;
        n_out_addr = r_out_addr;  n_out_bsize = r_out_bsize;  n_out_adj = r_out_adj;
        n_out_used = r_out_used;  n_out_live = r_out_live;

        mem_we = 1'b0;  mem_waddr = '0;  mem_wdata = '0;  mem_raddr = '0;

        init_base  = r_pool_base & END_LIMIT;
        init_avail = END_LIMIT - init_base;
        rem        = r_best_seg.len - r_btot;
        prev_end   = {1'b0, r_prev.start} + {1'b0, r_prev.len};
        mprev      = r_has_prev && (prev_end == {1'b0, r_bstart});
        mnext      = r_has_next && ({1'b0, r_next.start} == r_bend);

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                mem_we          = 1'b1;
                mem_waddr       = '0;
                mem_wdata.start = init_base;
                mem_wdata.len   = (r_pool_size > init_avail) ? init_avail : r_pool_size;
                n_cnt  = (mem_wdata.len != '0) ? ONE : '0;
                n_used = '0;
                n_live = '0;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_cfg_valid) begin
                    if (i_cfg_index == CFG_POOL_BASE) begin
                        n_pool_base = i_cfg_data;
                    end else begin
                        n_pool_size = i_cfg_data;
                    end
                    n_state = S_INIT;
                end else if (accept) begin
                    n_status = ST_OK;  n_addr = '0;  n_bsize = '0;  n_adj = '0;
                    n_fin_we = 1'b0;   n_has_best = 1'b0;
                    n_has_prev = 1'b0; n_has_next = 1'b0;
                    n_idx = '0;
                    n_size = i_req_size;
                    n_lg   = i_align_log2;
                    if (i_req_type == REQ_ALLOC) begin
                        if (i_align_log2 > MAX_ALIGN_LOG2) begin
                            n_status = ST_NO_FIT;
                            n_state  = S_DONE;
                        end else if (r_cnt == '0) begin
                            n_state = S_ADEC;
                        end else begin
                            n_state = S_ARD;
                        end
                    end else begin
                        n_bstart = i_free_addr - {20'd0, i_free_adjust};
                        n_fsize  = i_free_size;
                        n_bad    = ({20'd0, i_free_adjust} > i_free_addr) || (i_free_size == '0);
                        n_state  = S_FPRE;
                    end
                end
            end
            S_ARD: begin
                mem_raddr = r_idx[IW-1:0];
                n_state   = S_AEV;
            end
            S_AEV: begin
                n_state = ((r_idx + ONE) == r_cnt) ? S_ADEC : S_ARD;
                n_idx   = r_idx + ONE;
                if (fit_ok && (!r_has_best || mem_rdata.len < r_best_seg.len)) begin
                    n_has_best = 1'b1;
                    n_best     = r_idx;
                    n_best_seg = mem_rdata;
                    n_badj     = fit_adj;
                    n_btot     = fit_total;
                    if (fit_exact) begin
                        n_state = S_ADEC;
                    end
                end
            end
            S_ADEC: begin
                if (!r_has_best) begin
                    n_status = ST_NO_FIT;
                    n_state  = S_DONE;
                end else begin
                    n_addr = r_best_seg.start + {20'd0, r_badj};
                    n_adj  = r_badj;
                    n_live = r_live + 32'd1;
                    if (rem <= 32'(HEADER_BYTES)) begin
                        // whole segment goes out, close the gap in the table
                        n_bsize = r_best_seg.len;
                        n_used  = r_used + r_best_seg.len;
                        n_cnt   = r_cnt - ONE;
                        n_mv    = r_best;
                        n_mv_last = r_cnt - ONE;
                        n_mv_rm = 1'b1;
                        n_mv_wr = 1'b0;
                        n_state = ((r_best + ONE) < r_cnt) ? S_MOVE : S_DONE;
                    end else begin
                        n_bsize    = r_btot;
                        n_used     = r_used + r_btot;
                        n_fin_we   = 1'b1;
                        n_fin_addr = r_best[IW-1:0];
                        n_fin.start = r_best_seg.start + r_btot;
                        n_fin.len   = rem;
                        n_state    = S_DONE;
                    end
                end
            end
            S_FPRE: begin
                n_bend = {1'b0, r_bstart} + {1'b0, r_fsize};
                if (r_bad || n_bend > {1'b0, END_LIMIT}) begin
                    n_status = ST_NO_FIT;
                    n_state  = S_DONE;
                end else begin
                    n_state = (r_cnt == '0) ? S_FCHK : S_FRD;
                end
            end
            S_FRD: begin
                mem_raddr = r_idx[IW-1:0];
                n_state   = S_FEV;
            end
            S_FEV: begin
                if (mem_rdata.start < r_bstart) begin
                    n_prev     = mem_rdata;
                    n_has_prev = 1'b1;
                    n_idx      = r_idx + ONE;
                    n_state    = ((r_idx + ONE) == r_cnt) ? S_FCHK : S_FRD;
                end else begin
                    n_next     = mem_rdata;
                    n_has_next = 1'b1;
                    n_state    = S_FCHK;
                end
            end
            S_FCHK: begin
                n_state = S_DONE;
                if ((r_has_prev && prev_end > {1'b0, r_bstart})
                    || (r_has_next && {1'b0, r_next.start} < r_bend)) begin
                    n_status = ST_NO_FIT;
                end else if (!mprev && !mnext && r_cnt == CNT_MAX) begin
                    n_status = ST_FULL;
                end else begin
                    n_live   = r_live - 32'd1;
                    n_used   = r_used - r_fsize;
                    n_fin_we = 1'b1;
                    n_mv_wr  = 1'b0;
                    if (mprev && mnext) begin
                        n_fin_addr  = IW'(r_idx - ONE);
                        n_fin.start = r_prev.start;
                        n_fin.len   = r_prev.len + r_fsize + r_next.len;
                        n_cnt     = r_cnt - ONE;
                        n_mv      = r_idx;
                        n_mv_last = r_cnt - ONE;
                        n_mv_rm   = 1'b1;
                        if ((r_idx + ONE) < r_cnt) begin
                            n_state = S_MOVE;
                        end
                    end else if (mprev) begin
                        n_fin_addr  = IW'(r_idx - ONE);
                        n_fin.start = r_prev.start;
                        n_fin.len   = r_prev.len + r_fsize;
                    end else if (mnext) begin
                        n_fin_addr  = r_idx[IW-1:0];
                        n_fin.start = r_bstart;
                        n_fin.len   = r_next.len + r_fsize;
                    end else begin
                        n_fin_addr  = r_idx[IW-1:0];
                        n_fin.start = r_bstart;
                        n_fin.len   = r_fsize;
                        n_cnt     = r_cnt + ONE;
                        n_mv      = r_cnt - ONE;
                        n_mv_last = r_idx;
                        n_mv_rm   = 1'b0;
                        if (r_cnt > r_idx) begin
                            n_state = S_MOVE;
                        end
                    end
                end
            end
            S_MOVE: begin
                // remove: entry j+1 -> j, upward; insert: entry j -> j+1, downward
                if (!r_mv_wr) begin
                    mem_raddr = r_mv_rm ? IW'(r_mv + ONE) : r_mv[IW-1:0];
                    n_mv_wr   = 1'b1;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_mv_rm ? r_mv[IW-1:0] : IW'(r_mv + ONE);
                    mem_wdata = mem_rdata;
                    n_mv_wr   = 1'b0;
                    if (r_mv_rm) begin
                        n_mv = r_mv + ONE;
                        if ((r_mv + ONE) == r_mv_last) begin
                            n_state = S_DONE;
                        end
                    end else begin
                        n_mv = r_mv - ONE;
                        if (r_mv == r_mv_last) begin
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_DONE: begin
                if (r_fin_we) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_fin_addr;
                    mem_wdata = r_fin;
                    n_fin_we  = 1'b0;
                end
                if (!r_out_valid || !i_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_addr   = r_addr;
                    n_out_bsize  = r_bsize;
                    n_out_adj    = r_adj;
                    n_out_used   = r_used;
                    n_out_live   = r_live;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_mv_wr     <= 1'b0;
            r_fin_we    <= 1'b0;
            r_out_valid <= 1'b0;
            r_pool_base <= '0;
            r_pool_size <= 32'd65536;
            r_cnt       <= '0;
            r_used      <= '0;
            r_live      <= '0;
        end else begin
            r_state     <= n_state;
            r_mv_wr     <= n_mv_wr;
            r_fin_we    <= n_fin_we;
            r_out_valid <= n_out_valid;
            r_pool_base <= n_pool_base;
            r_pool_size <= n_pool_size;
            r_cnt       <= n_cnt;
            r_used      <= n_used;
            r_live      <= n_live;
        end
        r_idx <= n_idx;  r_mv <= n_mv;  r_mv_last <= n_mv_last;  r_mv_rm <= n_mv_rm;
        r_size <= n_size;  r_lg <= n_lg;  r_has_best <= n_has_best;  r_best <= n_best;
        r_best_seg <= n_best_seg;  r_badj <= n_badj;  r_btot <= n_btot;
        r_bstart <= n_bstart;  r_fsize <= n_fsize;  r_bend <= n_bend;  r_bad <= n_bad;
        r_has_prev <= n_has_prev;  r_has_next <= n_has_next;
        r_prev <= n_prev;  r_next <= n_next;
        r_fin_addr <= n_fin_addr;  r_fin <= n_fin;
        r_status <= n_status;  r_addr <= n_addr;  r_bsize <= n_bsize;  r_adj <= n_adj;
        r_out_status <= n_out_status;  r_out_addr <= n_out_addr;
        r_out_bsize <= n_out_bsize;  r_out_adj <= n_out_adj;
        r_out_used <= n_out_used;  r_out_live <= n_out_live;
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_addr        = r_out_addr;
    assign o_block_size  = r_out_bsize;
    assign o_adjust      = r_out_adj;
    assign o_used_bytes  = r_out_used;
    assign o_alloc_count = r_out_live;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("segment count past table depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_cfg_valid |=> o_stall)
        else $error("request accepted but block not busy");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_DONE))
        else $error("result appeared outside completion state");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_state != S_INIT) && (r_cnt != $past(r_cnt))
        |-> (r_cnt == $past(r_cnt) + ONE) || (r_cnt == $past(r_cnt) - ONE))
        else $error("segment count moved by more than one");
`endif

endmodule
`default_nettype wire

>>> hdl/bffl_seg_mem.sv
`default_nettype none
module bffl_seg_mem #(
    parameter int DEPTH = 16,
    parameter int IW    = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [IW-1:0] i_waddr,
    input  wire bffl_pkg::t_seg i_wdata,
    input  wire logic [IW-1:0] i_raddr,
    output bffl_pkg::t_seg     o_rdata
);
    import bffl_pkg::*;

    t_seg r_mem [DEPTH];
    t_seg r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> hdl/bffl_fit.sv
`default_nettype none
module bffl_fit (
    input  wire bffl_pkg::t_seg                     i_seg,
    input  wire logic [bffl_pkg::DATA_W-1:0]        i_size,
    input  wire logic [bffl_pkg::LOG2_W-1:0]        i_lg,
    output logic [bffl_pkg::ADJ_W-1:0]              o_adj,
    output logic [bffl_pkg::DATA_W-1:0]             o_total,
    output logic                                    o_fit,
    output logic                                    o_exact
);
    import bffl_pkg::*;

    logic [DATA_W+1:0] mask;
    logic [DATA_W+1:0] aligned;
    logic [DATA_W+1:0] adj_w;
    logic [DATA_W:0]   total_w;
    logic              adj_ok;

    always_comb begin
        mask    = (34'd1 << i_lg) - 34'd1;
        aligned = ({2'b00, i_seg.start} + 34'(HEADER_BYTES) + mask) & ~mask;
        adj_w   = aligned - {2'b00, i_seg.start};
        adj_ok  = adj_w <= {22'd0, ADJ_MAX};
        total_w = {1'b0, i_size} + {21'd0, adj_w[ADJ_W-1:0]};
        o_adj   = adj_w[ADJ_W-1:0];
        o_total = total_w[DATA_W-1:0];
        o_fit   = adj_ok && ({1'b0, i_seg.len} >= total_w);
        o_exact = o_fit && ({1'b0, i_seg.len} == total_w);
    end

endmodule
`default_nettype wire
